// ----- rtl/fbd_pkg.sv -----
// Shared types and constants for the flag-delimited bit deframer.
// No dependencies; imported by every module of the block.
package fbd_pkg;

	localparam int DATA_W    = 8;
	localparam int GAP_W     = 16;
	localparam int TIME_W    = 32;
	localparam int OUT_IDX_W = 5;
	localparam int MAX_OUT   = 32;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 16;

	typedef enum logic [0:0] {
		CFG_MIN_GAP = 1'b0,
		CFG_FLAG    = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_RUN,
		ST_READ,
		ST_SEND
	} state_t;

endpackage

// ----- rtl/flag_delimited_bit_deframer.sv -----
// Flag-delimited bit deframer: one bit per input transaction, bytes out on close.
// An input bit is processed in the cycle it is accepted. On a closing flag, the
// stored bytes leave one by one, each through a frame memory read, then the output
// register; no input is taken until the last byte transaction completes.
// Reset (arst_n low) clears all control state; the frame memory is not cleared.
// Depends on fbd_pkg and fbd_edge_filter.
module flag_delimited_bit_deframer
	import fbd_pkg::*;
#(
	parameter int FRAME_BYTES = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // edge_time_us[31:0], bit_value, zero pad
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // frame_byte[7:0], byte_index[4:0], zero pad
	output logic                   m_axis_tlast,
	input  logic                   cfg_we,
	input  logic [0:0]             cfg_index,
	input  logic [GAP_W-1:0]       cfg_data
);

	localparam int AW    = $clog2(FRAME_BYTES);
	localparam int BCW   = $clog2(FRAME_BYTES * 8 + 1);
	localparam int NBW   = BCW - 3;
	localparam int NMAX  = (FRAME_BYTES < MAX_OUT) ? FRAME_BYTES : MAX_OUT;
	localparam int FBITS = FRAME_BYTES * 8;

	logic [GAP_W-1:0]  min_gap_q;
	logic [DATA_W-1:0] flag_pat_q;

	state_t state_q, state_d;

	logic              seen_q, seen_d;
	logic [DATA_W-1:0] flag_q, flag_d;
	logic              in_frame_q, in_frame_d;
	logic [BCW-1:0]    bit_cnt_q, bit_cnt_d;
	logic [DATA_W-1:0] byte_q, byte_d;
	logic [AW-1:0]     rd_idx_q, rd_idx_d;
	logic [AW-1:0]     last_q, last_d;

	logic [DATA_W-1:0] frame_mem [FRAME_BYTES];
	logic [DATA_W-1:0] rdata_q;

	logic              take;
	logic              pass;
	logic [TIME_W-1:0] edge_time;
	logic              bit_in;
	logic [DATA_W-1:0] flag_sh;
	logic              match;
	logic [BCW-1:0]    bit_cnt_inc;
	logic [NBW-1:0]    nbytes;
	logic [NBW-1:0]    nclamp;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [DATA_W-1:0] wr_data;

	assign edge_time = s_axis_tdata[TIME_W-1:0];
	assign bit_in    = s_axis_tdata[TIME_W];
	assign take      = s_axis_tvalid && s_axis_tready;

	fbd_edge_filter u_filter (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.edge_time (edge_time),
		.min_gap   (min_gap_q),
		.pass      (pass)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_gap_q  <= GAP_W'(10);
			flag_pat_q <= DATA_W'(126);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MIN_GAP: min_gap_q  <= cfg_data;
				CFG_FLAG:    flag_pat_q <= cfg_data[DATA_W-1:0];
				default: ;
			endcase
		end
	end

	assign flag_sh     = {flag_q[DATA_W-2:0], bit_in};
	assign match       = (flag_sh == flag_pat_q);
	assign bit_cnt_inc = bit_cnt_q + BCW'(1);
	assign nbytes      = bit_cnt_inc[BCW-1:3];
	assign nclamp      = (nbytes > NBW'(NMAX)) ? NBW'(NMAX) : nbytes;
	assign wr_addr     = AW'(bit_cnt_q[BCW-1:3]);
	assign wr_data     = {bit_in, byte_q[DATA_W-1:1]};

	always_comb begin
		state_d    = state_q;
		seen_d     = seen_q;
		flag_d     = flag_q;
		in_frame_d = in_frame_q;
		bit_cnt_d  = bit_cnt_q;
		byte_d     = byte_q;
		rd_idx_d   = rd_idx_q;
		last_d     = last_q;
		wr_en      = 1'b0;
		s_axis_tready = 1'b0;
		m_axis_tvalid = 1'b0;
		unique case (state_q)
			ST_RUN: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid && pass && (seen_q || !bit_in)) begin
					seen_d = 1'b1;
					flag_d = flag_sh;
					if (in_frame_q) begin
						byte_d    = wr_data;
						bit_cnt_d = bit_cnt_inc;
						wr_en     = (bit_cnt_q[2:0] == 3'd7);
						if (match) begin
							seen_d     = 1'b0;
							flag_d     = '0;
							in_frame_d = 1'b0;
							bit_cnt_d  = '0;
							if (nbytes != '0) begin
								rd_idx_d = '0;
								last_d   = AW'(nclamp - NBW'(1));
								state_d  = ST_READ;
							end
						end else if (bit_cnt_inc >= BCW'(FBITS)) begin
							seen_d     = 1'b0;
							flag_d     = '0;
							bit_cnt_d  = '0;
							in_frame_d = (flag_pat_q == '0);
						end
					end else if (match) begin
						in_frame_d = 1'b1;
					end
				end
			end
			ST_READ: begin
				state_d = ST_SEND;
			end
			ST_SEND: begin
				m_axis_tvalid = 1'b1;
				if (m_axis_tready) begin
					if (rd_idx_q == last_q) begin
						state_d = ST_RUN;
					end else begin
						rd_idx_d = rd_idx_q + AW'(1);
						state_d  = ST_READ;
					end
				end
			end
			default: state_d = ST_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_RUN;
			seen_q     <= 1'b0;
			flag_q     <= '0;
			in_frame_q <= 1'b0;
			bit_cnt_q  <= '0;
			rd_idx_q   <= '0;
			last_q     <= '0;
		end else begin
			state_q    <= state_d;
			seen_q     <= seen_d;
			flag_q     <= flag_d;
			in_frame_q <= in_frame_d;
			bit_cnt_q  <= bit_cnt_d;
			rd_idx_q   <= rd_idx_d;
			last_q     <= last_d;
		end
	end

	always_ff @(posedge clk) begin
		byte_q <= byte_d;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			frame_mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			rdata_q <= frame_mem[rd_idx_q];
		end
	end

	assign m_axis_tdata = {(OUT_TDATA_W - DATA_W - OUT_IDX_W)'(0), OUT_IDX_W'(rd_idx_q), rdata_q};
	assign m_axis_tlast = (rd_idx_q == last_q);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input taken while a byte is pending");

	a_resume: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
		else $error("no return to input after last byte");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_RUN) |-> (rd_idx_q <= last_q))
		else $error("read index beyond last byte");

	a_frame_open: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_RUN) |-> (!in_frame_q && !seen_q && bit_cnt_q == '0))
		else $error("frame state not idle during byte transactions");

endmodule

// ----- rtl/fbd_edge_filter.sv -----
// Glitch filter: drops edges closer than the minimum gap to the last kept edge.
// Depends on fbd_pkg.
module fbd_edge_filter
	import fbd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [TIME_W-1:0] edge_time,
	input  logic [GAP_W-1:0]  min_gap,
	output logic              pass
);

	logic [TIME_W-1:0] last_edge_q;
	logic [TIME_W-1:0] delta;

	assign delta = edge_time - last_edge_q;
	assign pass  = !(delta < TIME_W'(min_gap));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_edge_q <= '0;
		end else if (take && pass) begin
			last_edge_q <= edge_time;
		end
	end

endmodule
